// ----- rtl/mtfrt_pkg.sv -----
// Shared types and constants for the move-to-front rank transform.
// Depends on nothing; every rtl file imports it.
package mtfrt_pkg;

    // Alphabet and field widths
    localparam int SYMBOL_BITS = 8;
    localparam int ALPHA       = 1 << SYMBOL_BITS;
    localparam int VAL_BITS    = SYMBOL_BITS + 1;
    localparam int CNT_BITS    = SYMBOL_BITS + 1;
    localparam int IDX_BITS    = SYMBOL_BITS;

    localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(ALPHA);
    localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(ALPHA - 1);

    // Register map
    localparam int PADDR_BITS   = 3;
    localparam int REG_IDX_BITS = 1;
    localparam logic [REG_IDX_BITS-1:0] REG_DIRECTION = 1'b0;
    localparam logic DIR_ENCODE = 1'b0;

    // Channel beats
    typedef struct packed {
        logic                stream_start;
        logic [VAL_BITS-1:0] in_value;
    } t_in_beat;

    typedef struct packed {
        logic [VAL_BITS-1:0] out_value;
        logic                first_seen;
        logic                bad_code;
    } t_out_beat;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_FETCH,
        ST_SEARCH,
        ST_SHIFT,
        ST_FINISH
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic rd_rank;
        logic search_start;
        logic search;
        logic set_bad;
        logic fetch;
        logic shift;
        logic emit;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic dir;
        logic esc;
        logic rank_ok;
        logic hit;
        logic miss;
        logic last;
        logic out_free;
    } t_stat;

endpackage

// ----- rtl/move_to_front_rank_transform.sv -----
// Top level of the move-to-front rank transform: APB register and wiring.
// Depends on mtfrt_pkg, mtfrt_ctrl and mtfrt_dp.
//
// Usage: the input channel takes one beat (stream_start, in_value) when
// i_in_valid is high and o_in_stall is low; the output channel gives one
// beat (out_value, first_seen, bad_code) per input beat, taken when
// o_out_valid is high and i_out_stall is low. The direction register at
// byte address 0 selects encode (0) or decode (1); write it only while idle.
// Each item walks the recency list in one memory, one entry per cycle:
// a search reads entries until the symbol is found at position p or the
// n symbols seen run out, then a shift rewrites positions 0..p, or up to
// the new slot on a miss. One item is in work at a time; the input side
// stalls from acceptance until the result is loaded into the output
// register, so the next item may enter while that result waits.
// Reset clears the seen count, the direction and the output valid; the
// list memory needs no clearing. A stalled receiver holds the finished
// result and blocks completion of the following item only.
module move_to_front_rank_transform
    import mtfrt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_beat              i_in_beat,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_beat             o_out_beat,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_BITS-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    logic  r_direction;
    logic  reg_hit;
    t_cmd  cmd;
    t_stat stat;

    assign reg_hit = (paddr[PADDR_BITS-1:2] == REG_DIRECTION);
    assign pready  = 1'b1;

    // Write the direction register on the access beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_direction <= DIR_ENCODE;
        end else if (psel && penable && pwrite && pready && reg_hit) begin
            r_direction <= pwdata[0];
        end
    end

    // Read back
    assign prdata = reg_hit ? {31'b0, r_direction} : 32'b0;

    mtfrt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    mtfrt_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_dir       (r_direction),
        .i_in_beat   (i_in_beat),
        .i_cmd       (cmd),
        .i_out_stall (i_out_stall),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_out_beat  (o_out_beat)
    );

endmodule

// ----- rtl/mtfrt_ctrl.sv -----
// Sequencer for one item: dispatch, search or fetch, shift (skipped for a bad code), deliver.
// Depends on mtfrt_pkg; drives the command struct of mtfrt_dp.
module mtfrt_ctrl
    import mtfrt_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_in_stall
);

    t_state r_state;
    t_state n_state;

    // Hold the state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Pick the next state and the commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                o_cmd.rd_rank = 1'b1;
                if (i_stat.dir == DIR_ENCODE || i_stat.esc) begin
                    o_cmd.search_start = 1'b1;
                    n_state            = ST_SEARCH;
                end else if (i_stat.rank_ok) begin
                    n_state = ST_FETCH;
                end else begin
                    o_cmd.set_bad = 1'b1;
                    n_state       = ST_FINISH;
                end
            end
            ST_FETCH: begin
                o_cmd.fetch = 1'b1;
                n_state     = ST_SHIFT;
            end
            ST_SEARCH: begin
                o_cmd.search = 1'b1;
                if (i_stat.hit && i_stat.dir != DIR_ENCODE) begin
                    n_state = ST_FINISH;
                end else if (i_stat.hit || i_stat.miss) begin
                    n_state = ST_SHIFT;
                end
            end
            ST_SHIFT: begin
                o_cmd.shift = 1'b1;
                if (i_stat.last) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != ST_IDLE);

endmodule

// ----- rtl/mtfrt_dp.sv -----
// Datapath: recency list memory, seen count, walk index and result register.
// Depends on mtfrt_pkg; steered by mtfrt_ctrl through t_cmd.
module mtfrt_dp
    import mtfrt_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_dir,
    input  t_in_beat  i_in_beat,
    input  t_cmd      i_cmd,
    input  logic      i_out_stall,
    output t_stat     o_stat,
    output logic      o_out_valid,
    output t_out_beat o_out_beat
);

    logic [SYMBOL_BITS-1:0] r_mem [ALPHA];
    logic [SYMBOL_BITS-1:0] r_rdata;

    logic [CNT_BITS-1:0]    r_count;
    logic                   r_out_valid;
    t_out_beat              r_out;

    logic [VAL_BITS-1:0]    r_v;
    logic [SYMBOL_BITS-1:0] r_sym;
    logic                   r_dir;
    logic [CNT_BITS-1:0]    r_idx;
    logic [CNT_BITS-1:0]    r_lag_idx;
    logic                   r_lag_v;
    logic [CNT_BITS-1:0]    r_pos;
    logic [VAL_BITS-1:0]    r_res;
    logic                   r_first;
    logic                   r_bad;
    logic                   r_ins;

    logic [IDX_BITS-1:0]    rd_addr;
    logic [SYMBOL_BITS-1:0] wr_data;
    logic                   idx_live;
    logic                   hit;
    logic                   miss;

    // Read the rank entry while dispatching, else the walk position
    assign rd_addr  = i_cmd.rd_rank ? r_v[IDX_BITS-1:0] : r_idx[IDX_BITS-1:0];
    // Front gets the moved symbol, every later slot its predecessor
    assign wr_data  = (r_idx == '0) ? r_sym : r_rdata;
    assign idx_live = (r_idx < r_count);
    assign hit      = r_lag_v && (r_rdata == r_sym);
    assign miss     = !r_lag_v && !idx_live;

    // Recency list: read before write at the same address
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[rd_addr];
        if (i_cmd.shift) begin
            r_mem[r_idx[IDX_BITS-1:0]] <= wr_data;
        end
    end

    // Seen count and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load && i_in_beat.stream_start) begin
                r_count <= '0;
            end else if (i_cmd.emit && r_ins && r_count != CNT_FULL) begin
                r_count <= r_count + 1'b1;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Item registers: capture, search, fetch, shift
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_v     <= i_in_beat.in_value;
            r_sym   <= i_in_beat.in_value[SYMBOL_BITS-1:0];
            r_dir   <= i_dir;
            r_res   <= '0;
            r_first <= 1'b0;
            r_bad   <= 1'b0;
            r_ins   <= 1'b0;
        end
        if (i_cmd.set_bad) begin
            r_bad <= 1'b1;
        end
        if (i_cmd.search_start) begin
            r_idx   <= '0;
            r_lag_v <= 1'b0;
        end
        if (i_cmd.search) begin
            if (hit) begin
                r_pos <= r_lag_idx;
                r_idx <= '0;
                if (r_dir != DIR_ENCODE) begin
                    r_bad <= 1'b1;
                end else begin
                    r_res <= r_lag_idx;
                end
            end else if (miss) begin
                r_pos   <= (r_count == CNT_FULL) ? CNT_LAST : r_count;
                r_idx   <= '0;
                r_first <= 1'b1;
                r_ins   <= 1'b1;
                r_res   <= (r_dir != DIR_ENCODE) ? {1'b0, r_sym} : {1'b1, r_sym};
            end else begin
                r_lag_v   <= idx_live;
                r_lag_idx <= r_idx;
                if (idx_live) begin
                    r_idx <= r_idx + 1'b1;
                end
            end
        end
        if (i_cmd.fetch) begin
            r_sym <= r_rdata;
            r_res <= {1'b0, r_rdata};
            r_pos <= r_v;
            r_idx <= '0;
        end
        if (i_cmd.shift) begin
            r_idx <= r_idx + 1'b1;
        end
        if (i_cmd.emit) begin
            r_out.out_value  <= r_res;
            r_out.first_seen <= r_first;
            r_out.bad_code   <= r_bad;
        end
    end

    // Report status
    always_comb begin
        o_stat.dir      = r_dir;
        o_stat.esc      = r_v[SYMBOL_BITS];
        o_stat.rank_ok  = !r_v[SYMBOL_BITS] && (r_v < r_count);
        o_stat.hit      = hit;
        o_stat.miss     = miss;
        o_stat.last     = (r_idx == r_pos);
        o_stat.out_free = !r_out_valid || !i_out_stall;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

endmodule

// ----- tb/mtfrt_rank_checker.sv -----
// Scoreboard for the move-to-front rank transform: watches both channels and the APB port.
// Keeps its own recency list and compares every result beat with its prediction.
// Depends on mtfrt_pkg.
module mtfrt_rank_checker
    import mtfrt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  t_in_beat              i_in_beat,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  t_out_beat             i_out_beat,
    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic                  i_pready,
    input  logic [PADDR_BITS-1:0] i_paddr,
    input  logic [31:0]           i_pwdata,
    output int                    o_failures,
    output int                    o_pending
);

    localparam logic [PADDR_BITS-1:0] DIRECTION_ADDR = PADDR_BITS'(4 * REG_DIRECTION);

    logic [SYMBOL_BITS-1:0] recent [ALPHA];
    int                     n_listed   = 0;
    logic                   coding_dir = DIR_ENCODE;
    t_out_beat              awaited [$];
    int                     mismatches = 0;

    assign o_failures = mismatches;

    // Position of a symbol in the list, or the list length when absent
    function automatic int find_rank(logic [SYMBOL_BITS-1:0] sym);
        for (int i = 0; i < n_listed; i++) begin
            if (recent[i] == sym) return i;
        end
        return n_listed;
    endfunction

    // Slide entries 0..pos-1 down one place and put sym in front
    function automatic void move_front(int pos, logic [SYMBOL_BITS-1:0] sym);
        for (int i = pos; i > 0; i--) recent[i] = recent[i-1];
        recent[0] = sym;
    endfunction

    // Put a new symbol in front and count it, saturating at a full alphabet
    function automatic void add_symbol(logic [SYMBOL_BITS-1:0] sym);
        move_front((n_listed < ALPHA) ? n_listed : ALPHA - 1, sym);
        if (n_listed < ALPHA) n_listed++;
    endfunction

    // Work out the result beat of one input beat and update the list
    function automatic t_out_beat predict_rank(t_in_beat beat);
        t_out_beat              res;
        logic [SYMBOL_BITS-1:0] sym;
        int                     pos;
        res = '0;
        sym = beat.in_value[SYMBOL_BITS-1:0];
        if (beat.stream_start) n_listed = 0;
        if (coding_dir == DIR_ENCODE) begin
            // the top bit of the value is ignored when encoding
            pos = find_rank(sym);
            if (pos < n_listed) begin
                res.out_value = VAL_BITS'(pos);
                move_front(pos, sym);
            end else begin
                res.out_value  = {1'b1, sym};
                res.first_seen = 1'b1;
                add_symbol(sym);
            end
        end else if (!beat.in_value[SYMBOL_BITS]) begin
            // plain rank: must name a listed position
            pos = int'(beat.in_value);
            if (pos < n_listed) begin
                res.out_value = VAL_BITS'(recent[pos]);
                move_front(pos, recent[pos]);
            end else begin
                res.bad_code = 1'b1;
            end
        end else if (find_rank(sym) < n_listed) begin
            // escape of a symbol already seen
            res.bad_code = 1'b1;
        end else begin
            res.out_value  = VAL_BITS'(sym);
            res.first_seen = 1'b1;
            add_symbol(sym);
        end
        return res;
    endfunction

    // Track register writes, predict accepted beats, compare taken results
    always @(posedge i_clk) begin
        t_out_beat want;
        if (!i_rst_n) begin
            n_listed   = 0;
            coding_dir = DIR_ENCODE;
            awaited.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == DIRECTION_ADDR) begin
                coding_dir = i_pwdata[0];
            end
            if (i_out_valid && !i_out_stall) begin
                if (awaited.size() == 0) begin
                    $error("unexpected result beat: out_value %0d", i_out_beat.out_value);
                    mismatches++;
                end else begin
                    want = awaited.pop_front();
                    if (i_out_beat.out_value !== want.out_value) begin
                        $error("out_value: expected %0d, got %0d",
                               want.out_value, i_out_beat.out_value);
                        mismatches++;
                    end
                    if (i_out_beat.first_seen !== want.first_seen) begin
                        $error("first_seen: expected %0d, got %0d",
                               want.first_seen, i_out_beat.first_seen);
                        mismatches++;
                    end
                    if (i_out_beat.bad_code !== want.bad_code) begin
                        $error("bad_code: expected %0d, got %0d",
                               want.bad_code, i_out_beat.bad_code);
                        mismatches++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                awaited.push_back(predict_rank(i_in_beat));
            end
        end
        o_pending <= awaited.size();
    end

endmodule

// ----- tb/tb_move_to_front_rank_transform.sv -----
// Testbench top for the move-to-front rank transform: clock, reset, stimulus, verdict.
// Drives directed and random streams in both directions with random gaps and stalls.
// Depends on mtfrt_pkg, move_to_front_rank_transform and mtfrt_rank_checker.
module tb_move_to_front_rank_transform;
    import mtfrt_pkg::*;

    localparam logic                  DIR_DECODE     = ~DIR_ENCODE;
    localparam logic [PADDR_BITS-1:0] DIRECTION_ADDR = PADDR_BITS'(4 * REG_DIRECTION);
    localparam int                    PHASES         = 6;
    localparam int                    PHASE_ITEMS    = 313;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    t_in_beat              in_beat   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    t_out_beat             out_beat;
    logic                  psel      = 1'b0;
    logic                  penable   = 1'b0;
    logic                  pwrite    = 1'b0;
    logic [PADDR_BITS-1:0] paddr     = '0;
    logic [31:0]           pwdata    = '0;
    logic [31:0]           prdata;
    logic                  pready;
    int                    failures;
    int                    pending;

    // Stimulus state: direction, symbols introduced so far, symbol pool
    logic                   mode      = DIR_ENCODE;
    logic                   quiet     = 1'b0;
    logic                   long_hold = 1'b0;
    bit                     sym_used [ALPHA];
    int                     n_used    = 0;
    int                     issued    = 0;
    logic [SYMBOL_BITS-1:0] pool [16];
    int                     pool_size = 0;

    always #5 clk = ~clk;

    move_to_front_rank_transform dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_beat   (in_beat),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_beat  (out_beat),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    mtfrt_rank_checker rank_check (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_beat   (in_beat),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_beat  (out_beat),
        .i_psel      (psel),
        .i_penable   (penable),
        .i_pwrite    (pwrite),
        .i_pready    (pready),
        .i_paddr     (paddr),
        .i_pwdata    (pwdata),
        .o_failures  (failures),
        .o_pending   (pending)
    );

    // Idle length: mostly none or short, now and then long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 15);
        return $urandom_range(30, 80);
    endfunction

    function automatic void clear_shadow();
        foreach (sym_used[i]) sym_used[i] = 1'b0;
        n_used = 0;
    endfunction

    // Send one input beat, hold it until taken, then idle a while
    task automatic issue(input logic start, input logic [VAL_BITS-1:0] val);
        logic [SYMBOL_BITS-1:0] s;
        int                     idle;
        s = val[SYMBOL_BITS-1:0];
        if (start) clear_shadow();
        if ((mode == DIR_ENCODE || val[SYMBOL_BITS]) && !sym_used[s]) begin
            sym_used[s] = 1'b1;
            n_used++;
        end
        issued++;
        in_valid <= 1'b1;
        in_beat  <= '{stream_start: start, in_value: val};
        do @(posedge clk); while (in_stall);
        idle = quiet ? 0 : gap_len();
        if (idle != 0) begin
            in_valid <= 1'b0;
            repeat (idle) @(posedge clk);
        end
    endtask

    // Wait until every result has come back and the block is idle
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // APB write of the direction register, only while idle
    task automatic write_direction(input logic value);
        drain();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= DIRECTION_ADDR;
        pwdata  <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        mode = value;
    endtask

    // Mostly well-formed values drawn from the pool, with some noise
    function automatic logic [VAL_BITS-1:0] next_value();
        int                     r;
        logic [SYMBOL_BITS-1:0] s;
        r = $urandom_range(0, 99);
        s = pool[$urandom_range(0, pool_size - 1)];
        if (mode == DIR_ENCODE) begin
            if (r < 8) return VAL_BITS'($urandom);
            return {1'b0, s};
        end
        if (r < 4) return VAL_BITS'($urandom);
        if (r < 8 && n_used < ALPHA) return VAL_BITS'($urandom_range(n_used, ALPHA - 1));
        if (r < 12 && sym_used[s]) return {1'b1, s};
        if (!sym_used[s] && (r < 55 || n_used == 0)) return {1'b1, s};
        if (n_used > 0) return VAL_BITS'($urandom_range(0, n_used - 1));
        return {1'b1, s};
    endfunction

    // A short stream over a small pool; usually restarts the list
    task automatic random_stream(input int count);
        logic st;
        if ($urandom_range(0, 99) < 85 || pool_size == 0) begin
            pool_size = $urandom_range(1, 16);
            foreach (pool[i]) pool[i] = SYMBOL_BITS'($urandom);
            st = 1'b1;
        end else begin
            st = 1'b0;
        end
        for (int i = 0; i < count; i++) begin
            if (st) clear_shadow();
            issue(st, next_value());
            st = ($urandom_range(0, 99) == 0);
        end
    endtask

    // Fill the list with the whole alphabet in random order, then hit its far end
    task automatic full_stream();
        logic [SYMBOL_BITS-1:0] order [ALPHA];
        logic [SYMBOL_BITS-1:0] t;
        int                     j;
        for (int i = 0; i < ALPHA; i++) order[i] = SYMBOL_BITS'(i);
        for (int i = ALPHA - 1; i > 0; i--) begin
            j        = $urandom_range(0, i);
            t        = order[i];
            order[i] = order[j];
            order[j] = t;
        end
        for (int i = 0; i < ALPHA; i++) begin
            if (mode == DIR_ENCODE) begin
                issue(i == 0, {1'($urandom), order[i]});
            end else begin
                issue(i == 0, {1'b1, order[i]});
                if ($urandom_range(0, 3) == 0) issue(1'b0, VAL_BITS'($urandom_range(0, i)));
            end
        end
        if (mode == DIR_ENCODE) begin
            // oldest symbol sits at the last position, then at the front
            issue(1'b0, {1'b0, order[0]});
            issue(1'b0, {1'b0, order[0]});
        end else begin
            // last position, front, and a repeated escape on a full list
            issue(1'b0, VAL_BITS'(ALPHA - 1));
            issue(1'b0, '0);
            issue(1'b0, {1'b1, order[5]});
        end
        for (int i = 0; i < 20; i++) begin
            if (mode == DIR_ENCODE) issue(1'b0, {1'b0, order[$urandom_range(0, ALPHA - 1)]});
            else issue(1'b0, VAL_BITS'($urandom_range(0, ALPHA - 1)));
        end
    endtask

    // Receiver: random stall runs, one long hold-off on request
    initial begin : result_sink
        int hold;
        bit hold_done;
        hold_done = 1'b0;
        forever begin
            if (long_hold && !hold_done) begin
                out_stall <= 1'b1;
                repeat (300) @(posedge clk);
                hold_done = 1'b1;
            end else if (!quiet) begin
                hold = gap_len();
                if (hold != 0) begin
                    out_stall <= 1'b1;
                    repeat (hold) @(posedge clk);
                end
            end
            out_stall <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    end

    // Stimulus and verdict
    initial begin : stimulus
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed encode: alphabet ends, hits, ignored top bit, restart
        write_direction(DIR_ENCODE);
        issue(1'b1, VAL_BITS'(0));
        issue(1'b0, VAL_BITS'(ALPHA - 1));
        issue(1'b0, VAL_BITS'(0));
        issue(1'b0, VAL_BITS'(2 * ALPHA - 1));
        issue(1'b0, VAL_BITS'(ALPHA + 'h55));
        issue(1'b1, VAL_BITS'(ALPHA - 1));
        issue(1'b0, VAL_BITS'('hAA));
        issue(1'b0, VAL_BITS'(ALPHA - 1));

        // directed decode: empty list, escapes, ranks past the count, repeats
        write_direction(DIR_DECODE);
        issue(1'b1, VAL_BITS'(0));
        issue(1'b0, VAL_BITS'(ALPHA));
        issue(1'b0, VAL_BITS'(2 * ALPHA - 1));
        issue(1'b0, VAL_BITS'(1));
        issue(1'b0, VAL_BITS'(0));
        issue(1'b0, VAL_BITS'(2));
        issue(1'b0, VAL_BITS'(ALPHA - 1));
        issue(1'b0, VAL_BITS'(ALPHA));
        issue(1'b0, VAL_BITS'(ALPHA + 'hAA));
        issue(1'b1, VAL_BITS'(ALPHA + 'hAA));
        issue(1'b1, VAL_BITS'(0));

        // random phases, alternating direction
        for (int ph = 0; ph < PHASES; ph++) begin
            write_direction((ph % 2 == 1) ? DIR_DECODE : DIR_ENCODE);
            quiet <= (ph == 4);
            if (ph == 1) long_hold <= 1'b1;
            if (ph == 2 || ph == 3) full_stream();
            while (issued < (ph + 1) * PHASE_ITEMS) random_stream($urandom_range(1, 40));
        end

        drain();
        repeat (20) @(posedge clk);
        if (failures == 0) begin
            $display("tb_move_to_front_rank_transform OK");
        end else begin
            $display("tb_move_to_front_rank_transform NOT OK");
        end
        $finish;
    end

    // Hang guard
    initial begin : watchdog
        #40_000_000;
        $display("tb_move_to_front_rank_transform NOT OK");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/mtfrt_pkg.sv
rtl/mtfrt_ctrl.sv
rtl/mtfrt_dp.sv
rtl/move_to_front_rank_transform.sv
tb/mtfrt_rank_checker.sv
tb/tb_move_to_front_rank_transform.sv
